### rtl/csr_sparse_matvec_defines.svh
// ---------------------------------------------------------------------------
// csr_sparse_matvec_defines.svh
// Assertion macros shared by the sparse matvec RTL.
// ---------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATVEC_DEFINES_SVH
`define CSR_SPARSE_MATVEC_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked every cycle outside reset.
`define CSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent this cycle, consequent the next.
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSM_ASSERT(lbl, prop, msg)
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/csm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csm_pkg
// Types, widths and operation codes for the sparse matvec block.
// ---------------------------------------------------------------------------
package csm_pkg;

  localparam int VEC_DEPTH_DEF = 1024;
  localparam int IDX_W         = 10;
  localparam int ROW_W         = 16;
  localparam int VAL_W         = 32;
  localparam int ACC_W         = 64;
  localparam int FRAC_W        = 16;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NONZERO = 2'd1;
  localparam logic [1:0] OP_EMPTY   = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        vector_index;
    logic signed [VAL_W-1:0] vector_value;
    logic signed [VAL_W-1:0] matrix_value;
    logic [IDX_W-1:0]        column;
    logic                    last_in_row;
    logic signed [VAL_W-1:0] addend;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] row_value;
    logic                    saturated;
  } out_item_t;

  // Item travelling from the read stage into the MAC.
  typedef struct packed {
    logic [1:0]              op;
    logic                    last;
    logic signed [VAL_W-1:0] matrix_value;
    logic signed [VAL_W-1:0] addend;
  } mac_item_t;

  // Finished row handed to the output stage.
  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [ACC_W-1:0] sum;
    logic signed [VAL_W-1:0] addend;
  } row_beat_t;

endpackage

### rtl/csr_sparse_matvec.sv
`timescale 1ns / 1ps
`include "csr_sparse_matvec_defines.svh"
// ---------------------------------------------------------------------------
// csr_sparse_matvec
// Compressed-row sparse matrix times dense vector, signed Q16.16.
// ---------------------------------------------------------------------------
// Load the dense vector first with load beats (operation 0), then stream the
// matrix row by row: one nonzero beat per entry, the last one marked, or an
// empty-row beat for a row with no entries. Each finished row produces one
// result beat carrying the row index, the 32-bit saturated result and a clip
// flag; a restart beat zeroes the row counter and the pending sum. The block
// takes one beat per clock with no gaps while result back-pressure does not
// stall it. A row result passes from the edge that takes its closing beat
// (which registers the beat and issues the vector memory read) through the
// multiply register, the row beat register and the output register. The
// accumulator loop is a single saturating 64-bit add of the product, and
// the vector memory serves one write or one read per beat. Result
// back-pressure stalls the pipe only once its stages are full. The vector
// memory has no reset; reading an element never loaded is undefined.
// accumulate_mode is written through the cfg channel, which is always ready,
// and should change only while the pipeline is drained.
// ---------------------------------------------------------------------------
module csr_sparse_matvec #(
  parameter int VEC_DEPTH = csm_pkg::VEC_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  csm_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output csm_pkg::out_item_t result
);

  logic                             accumulate_mode;
  logic                             item_fire;
  logic                             s1_valid;
  csm_pkg::mac_item_t               s1_item;
  logic                             mac_ready;
  logic signed [csm_pkg::VAL_W-1:0] vec_value;
  logic                             beat_valid;
  logic                             beat_ready;
  csm_pkg::row_beat_t               beat;

  // Mode register: single bit, never back-pressured.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulate_mode <= 1'b0;
    end else if (cfg_valid) begin
      accumulate_mode <= cfg_data;
    end
  end

  // Read stage. Loads finish at the memory write; everything else moves on.
  assign item_ready = !s1_valid || mac_ready;
  assign item_fire  = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid && (item.operation != csm_pkg::OP_LOAD);
    end
    if (item_fire) begin
      s1_item.op           <= item.operation;
      s1_item.last         <= item.last_in_row;
      s1_item.matrix_value <= item.matrix_value;
      s1_item.addend       <= item.addend;
    end
  end

  // Read data is held while the read stage stalls since reads only
  // happen on a taken beat.
  csm_vec_store #(
    .VEC_DEPTH(VEC_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (item_fire && (item.operation == csm_pkg::OP_LOAD)),
    .wr_index (item.vector_index),
    .wr_data  (item.vector_value),
    .rd_en    (item_fire && (item.operation == csm_pkg::OP_NONZERO)),
    .rd_index (item.column),
    .rd_data  (vec_value)
  );

  csm_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .vec_value  (vec_value),
    .ready      (mac_ready),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  csm_row_out u_out (
    .clk             (clk),
    .rst             (rst),
    .accumulate_mode (accumulate_mode),
    .beat_valid      (beat_valid),
    .beat            (beat),
    .beat_ready      (beat_ready),
    .result_valid    (result_valid),
    .result          (result),
    .result_ready    (result_ready)
  );

  `CSM_ASSERT_NEXT(a_nonzero_enters, item_fire && item.operation == csm_pkg::OP_NONZERO, s1_valid && s1_item.op == csm_pkg::OP_NONZERO, "taken nonzero missing from read stage")

endmodule

### rtl/csm_vec_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csm_vec_store
// Dense vector memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module csm_vec_store #(
  parameter int VEC_DEPTH = csm_pkg::VEC_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [csm_pkg::IDX_W-1:0]        wr_index,
  input  logic signed [csm_pkg::VAL_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [csm_pkg::IDX_W-1:0]        rd_index,
  output logic signed [csm_pkg::VAL_W-1:0] rd_data
);

  localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

  logic signed [csm_pkg::VAL_W-1:0] mem [VEC_DEPTH];
  logic signed [csm_pkg::VAL_W-1:0] rd_q;
  logic                             rd_hit;
  logic                             wr_in_range;
  logic                             rd_in_range;

  assign wr_in_range = int'(wr_index) < VEC_DEPTH;
  assign rd_in_range = int'(rd_index) < VEC_DEPTH;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[AW'(wr_index)] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[AW'(rd_index)];
      rd_hit <= rd_in_range;
    end
  end

  // Columns beyond the store read as zero.
  assign rd_data = rd_hit ? rd_q : '0;

endmodule

### rtl/csm_mac.sv
`timescale 1ns / 1ps
`include "csr_sparse_matvec_defines.svh"
// ---------------------------------------------------------------------------
// csm_mac
// Product stage and saturating row accumulator with row counter.
// ---------------------------------------------------------------------------
module csm_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s1_valid,
  input  csm_pkg::mac_item_t               s1_item,
  input  logic signed [csm_pkg::VAL_W-1:0] vec_value,
  output logic                             ready,
  output logic                             beat_valid,
  output csm_pkg::row_beat_t               beat,
  input  logic                             beat_ready
);

  logic                             s2_valid;
  csm_pkg::mac_item_t               s2_item;
  logic signed [csm_pkg::ACC_W-1:0] product;
  logic signed [csm_pkg::ACC_W-1:0] step;
  logic signed [csm_pkg::ACC_W:0]   sum_ext;
  logic signed [csm_pkg::ACC_W-1:0] sum_sat;
  logic signed [csm_pkg::ACC_W-1:0] total;
  logic signed [csm_pkg::ACC_W-1:0] row_sum;
  logic signed [csm_pkg::ACC_W-1:0] row_sum_next;
  logic [csm_pkg::ROW_W-1:0]        row_counter;
  logic [csm_pkg::ROW_W-1:0]        row_counter_next;
  logic                             s2_end;
  logic                             s2_go;

  assign s2_end = (s2_item.op == csm_pkg::OP_EMPTY) ||
                  ((s2_item.op == csm_pkg::OP_NONZERO) && s2_item.last);
  assign s2_go  = s2_valid && (!s2_end || beat_ready);
  assign ready  = !s2_valid || s2_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready) begin
      s2_valid <= s1_valid;
    end
    if (ready && s1_valid) begin
      s2_item <= s1_item;
      product <= $signed(s1_item.matrix_value) * $signed(vec_value);
    end
  end

  // Q32.32 product back to Q16.16, floor rounding.
  assign step    = product >>> csm_pkg::FRAC_W;
  assign sum_ext = {row_sum[csm_pkg::ACC_W-1], row_sum} + {step[csm_pkg::ACC_W-1], step};

  always_comb begin
    if (sum_ext[csm_pkg::ACC_W] != sum_ext[csm_pkg::ACC_W-1]) begin
      sum_sat = sum_ext[csm_pkg::ACC_W] ? csm_pkg::ACC_MIN : csm_pkg::ACC_MAX;
    end else begin
      sum_sat = sum_ext[csm_pkg::ACC_W-1:0];
    end
  end

  assign total = (s2_item.op == csm_pkg::OP_NONZERO) ? sum_sat : row_sum;

  always_comb begin
    row_sum_next     = row_sum;
    row_counter_next = row_counter;
    unique case (s2_item.op)
      csm_pkg::OP_NONZERO: begin
        if (s2_item.last) begin
          row_sum_next     = '0;
          row_counter_next = row_counter + 1'b1;
        end else begin
          row_sum_next = sum_sat;
        end
      end
      csm_pkg::OP_EMPTY: begin
        row_sum_next     = '0;
        row_counter_next = row_counter + 1'b1;
      end
      csm_pkg::OP_RESTART: begin
        row_sum_next     = '0;
        row_counter_next = '0;
      end
      default: begin
        row_sum_next     = row_sum;
        row_counter_next = row_counter;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum     <= '0;
      row_counter <= '0;
    end else if (s2_go) begin
      row_sum     <= row_sum_next;
      row_counter <= row_counter_next;
    end
  end

  assign beat_valid     = s2_valid && s2_end;
  assign beat.row_index = row_counter;
  assign beat.sum       = total;
  assign beat.addend    = s2_item.addend;

  `CSM_ASSERT_NEXT(a_row_count_step, s2_go && s2_end, row_counter == $past(row_counter) + 16'd1, "row counter did not advance by one")
  `CSM_ASSERT_NEXT(a_restart_clears, s2_go && s2_item.op == csm_pkg::OP_RESTART, row_counter == '0 && row_sum == '0, "restart left state behind")

endmodule

### rtl/csm_row_out.sv
`timescale 1ns / 1ps
`include "csr_sparse_matvec_defines.svh"
// ---------------------------------------------------------------------------
// csm_row_out
// Adds the beat's addend in accumulate mode, clips to 32 bits, output register.
// ---------------------------------------------------------------------------
module csm_row_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                accumulate_mode,
  input  logic                beat_valid,
  input  csm_pkg::row_beat_t  beat,
  output logic                beat_ready,
  output logic                result_valid,
  output csm_pkg::out_item_t  result,
  input  logic                result_ready
);

  logic                             s3_valid;
  csm_pkg::row_beat_t               s3;
  logic                             s4_free;
  logic                             s3_go;
  logic signed [csm_pkg::ACC_W:0]   addend_ext;
  logic signed [csm_pkg::ACC_W:0]   total;
  logic                             over_hi;
  logic                             over_lo;
  csm_pkg::out_item_t               result_next;

  assign s4_free    = !result_valid || result_ready;
  assign s3_go      = s3_valid && s4_free;
  assign beat_ready = !s3_valid || s3_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (beat_ready) begin
      s3_valid <= beat_valid;
    end
    if (beat_ready && beat_valid) begin
      s3 <= beat;
    end
  end

  // A 65-bit sum clipped to 32 bits matches saturating at 64 then clipping.
  assign addend_ext = accumulate_mode ?
    {{(csm_pkg::ACC_W+1-csm_pkg::VAL_W){s3.addend[csm_pkg::VAL_W-1]}}, s3.addend} : '0;
  assign total   = {s3.sum[csm_pkg::ACC_W-1], s3.sum} + addend_ext;
  assign over_hi = !total[csm_pkg::ACC_W] && (|total[csm_pkg::ACC_W-1:csm_pkg::VAL_W-1]);
  assign over_lo = total[csm_pkg::ACC_W] && !(&total[csm_pkg::ACC_W-1:csm_pkg::VAL_W-1]);

  always_comb begin
    result_next.row_index = s3.row_index;
    result_next.saturated = over_hi || over_lo;
    priority if (over_hi) begin
      result_next.row_value = csm_pkg::Q_MAX;
    end else if (over_lo) begin
      result_next.row_value = csm_pkg::Q_MIN;
    end else begin
      result_next.row_value = total[csm_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s4_free) begin
      result_valid <= s3_valid;
    end
    if (s3_go) begin
      result <= result_next;
    end
  end

  `CSM_ASSERT(a_sat_at_limit, result_valid && result.saturated |-> result.row_value == csm_pkg::Q_MAX || result.row_value == csm_pkg::Q_MIN, "saturated flag without clipped value")

endmodule
